### rtl/core/spn_pkg.sv
// Shared types, constants and helper functions for the SPN block cipher.
package spn_pkg;

   localparam int WORD_W         = 16;
   localparam int NIB_W          = 4;
   localparam int NUM_NIBS       = WORD_W / NIB_W;
   localparam int NUM_KEYS       = 4;
   localparam int CSR_IDX_W      = 2;
   localparam int DEFAULT_ROUNDS = 3;
   // Rounds past this one keep reusing its key.
   localparam int LAST_ROUND_KEY = 2;
   localparam int FINAL_KEY      = 3;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [NIB_W-1:0]  nibble_type;
   typedef word_type          key_array_type [NUM_KEYS];

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROUND_KEY_0 = 2'd0,
      CSR_ROUND_KEY_1 = 2'd1,
      CSR_ROUND_KEY_2 = 2'd2,
      CSR_ROUND_KEY_3 = 2'd3
   } csr_index_type;

   localparam nibble_type SBOX [16] = '{
      4'h5, 4'h2, 4'h6, 4'h8, 4'h1, 4'hd, 4'h7, 4'he,
      4'h4, 4'hf, 4'hc, 4'ha, 4'hb, 4'h3, 4'h0, 4'h9
   };

   // Output bit i (MSB first) takes input bit PERM[i] (MSB first).
   localparam logic [3:0] PERM [WORD_W] = '{
      4'd0, 4'd4, 4'd8,  4'd12, 4'd1, 4'd5, 4'd9,  4'd13,
      4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
   };

   function automatic word_type substitute(input word_type v);
      word_type res;
      res = '0;
      for (int n = 0; n < NUM_NIBS; n++) begin
         res[n*NIB_W +: NIB_W] = SBOX[v[n*NIB_W +: NIB_W]];
      end
      return res;
   endfunction

   function automatic word_type permute(input word_type v);
      word_type res;
      res = '0;
      for (int i = 0; i < WORD_W; i++) begin
         res[WORD_W-1-i] = v[WORD_W-1-int'(PERM[i])];
      end
      return res;
   endfunction

endpackage

### rtl/core/spn_if.sv
// Valid/ready stream interfaces for the plaintext and ciphertext channels.
interface spn_req_if;
   logic              valid;
   logic              ready;
   spn_pkg::word_type plaintext;

   modport source (output valid, output plaintext, input ready);
   modport sink   (input valid, input plaintext, output ready);
endinterface

interface spn_rsp_if;
   logic              valid;
   logic              ready;
   spn_pkg::word_type ciphertext;

   modport source (output valid, output ciphertext, input ready);
   modport sink   (input valid, input ciphertext, output ready);
endinterface

### rtl/core/spn_rounds.sv
// Unrolled SPN round datapath: key mix, S-box layer, bit transpose per round (none in the last).
module spn_rounds #(
   parameter int ROUNDS = spn_pkg::DEFAULT_ROUNDS
) (
   input  spn_pkg::word_type      plaintext,
   input  spn_pkg::key_array_type keys,
   output spn_pkg::word_type      ciphertext
);

   spn_pkg::word_type stage_val [ROUNDS];

   assign stage_val[0] = plaintext;

   // Full rounds: mix key, substitute, transpose.
   for (genvar r = 0; r < ROUNDS - 1; r++) begin : g_round
      localparam int KI = (r < spn_pkg::LAST_ROUND_KEY) ? r : spn_pkg::LAST_ROUND_KEY;
      assign stage_val[r+1] =
         spn_pkg::permute(spn_pkg::substitute(stage_val[r] ^ keys[KI]));
   end

   // Last round skips the transpose, then the final key goes on.
   localparam int LAST_KI = (ROUNDS - 1 < spn_pkg::LAST_ROUND_KEY) ?
                            ROUNDS - 1 : spn_pkg::LAST_ROUND_KEY;

   assign ciphertext = spn_pkg::substitute(stage_val[ROUNDS-1] ^ keys[LAST_KI])
                       ^ keys[spn_pkg::FINAL_KEY];

endmodule

### rtl/core/spn_block_cipher_encrypt.sv
// Top level of the 16-bit SPN block cipher encryptor.
// Encrypts one 16-bit plaintext word per cycle with a small substitution-permutation
// cipher: ROUNDS rounds (default 3, at least 1) of key XOR, 4-bit S-box on each
// nibble and a 4x4 bit transpose, the last round without transpose, then a final key
// XOR. A word accepted on req_if moves to rsp_if through the input register and the
// result register; the block takes a new word every cycle unless rsp_if stalls. The
// rate is set by the unrolled round logic, in one stage between the input register
// and the result register. Round keys live in four 16-bit registers written through
// the csr_ port (index 0 to 3, reset 0); write them only while no word is in flight.
module spn_block_cipher_encrypt #(
   parameter int ROUNDS = spn_pkg::DEFAULT_ROUNDS
) (
   input  logic                             clock,
   input  logic                             reset,
   spn_req_if.sink                          req_if,
   spn_rsp_if.source                        rsp_if,
   input  logic                             csr_we,
   input  logic [spn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  spn_pkg::word_type                csr_wdata
);

   spn_pkg::key_array_type key_ff, key_in;

   logic              s1_valid_ff, s1_valid_in;
   spn_pkg::word_type pt_ff, pt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   spn_pkg::word_type ct_ff, ct_in;
   spn_pkg::word_type cipher_comb;

   logic out_adv;
   logic s1_adv;

   // Key registers: load the addressed key, hold the rest.
   always_comb begin
      key_in = key_ff;
      if (csr_we) begin
         case (spn_pkg::csr_index_type'(csr_index))
            spn_pkg::CSR_ROUND_KEY_0: key_in[0] = csr_wdata;
            spn_pkg::CSR_ROUND_KEY_1: key_in[1] = csr_wdata;
            spn_pkg::CSR_ROUND_KEY_2: key_in[2] = csr_wdata;
            spn_pkg::CSR_ROUND_KEY_3: key_in[3] = csr_wdata;
            default: key_in = key_ff;
         endcase
      end
   end

   // Handshake: the result register frees up when empty or taken, and the
   // input register advances whenever its word can move on.
   assign out_adv = !rsp_valid_ff || rsp_if.ready;
   assign s1_adv  = !s1_valid_ff || out_adv;
   assign req_if.ready = s1_adv;

   always_comb begin
      s1_valid_in = s1_adv ? req_if.valid : s1_valid_ff;
      pt_in       = (s1_adv && req_if.valid) ? req_if.plaintext : pt_ff;
   end

   spn_rounds #(
      .ROUNDS (ROUNDS)
   ) u_rounds (
      .plaintext  (pt_ff),
      .keys       (key_ff),
      .ciphertext (cipher_comb)
   );

   always_comb begin
      rsp_valid_in = out_adv ? s1_valid_ff : rsp_valid_ff;
      ct_in        = (out_adv && s1_valid_ff) ? cipher_comb : ct_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < spn_pkg::NUM_KEYS; k++) begin
            key_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         key_ff       <= key_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
      ct_ff <= ct_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.ciphertext = ct_ff;

`ifndef ASSERT_OFF
   // An accepted word lands in the input register.
   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> s1_valid_ff)
      else $error("accepted word did not reach input register");

   // A word leaving the input register shows up as a result with its ciphertext.
   a_s1_to_rsp : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_adv |=> rsp_valid_ff && (ct_ff == $past(cipher_comb)))
      else $error("result register missed a word or its ciphertext");

   // An empty result register never blocks the input side.
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_if.ready)
      else $error("input stalled with empty result register");
`endif

endmodule
